[rtl/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W = 16;
  localparam int NUM_W = ELEM_W + 1;
  localparam int QUO_W = 18;

  typedef enum logic [1:0] {
    PC_TRACE = 2'd0,
    PC_XX    = 2'd1,
    PC_YY    = 2'd2,
    PC_ZZ    = 2'd3
  } pivot_e;

  typedef struct packed {
    pivot_e pc;
    logic   degen;
  } item_ctl_t;

  // unsigned bits of a positive radicand
  function automatic int rad_ubits(input int f);
    return ((f > 17) ? f : 17) + 1;
  endfunction

  // bits of the square root of radicand << f
  function automatic int sqrt_bits(input int f);
    return (rad_ubits(f) + f + 1) >> 1;
  endfunction

endpackage
`default_nettype wire

[rtl/rmq_prep.sv]
`default_nettype none
module rmq_prep #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [8:0][rmq_pkg::ELEM_W-1:0]   mat_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output rmq_pkg::item_ctl_t                     out_ctl_o,
  output logic [rmq_pkg::rad_ubits(FRAC_BITS)+FRAC_BITS-1:0] out_rad_o,
  output logic [2:0][rmq_pkg::NUM_W-1:0]         out_num_o
);
  import rmq_pkg::*;

  localparam int RU = rad_ubits(FRAC_BITS);
  localparam int RW = RU + 1;
  localparam int VW = RU + FRAC_BITS;

  logic signed [ELEM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [17:0]       tr;
  logic signed [RW-1:0]     one_c, e00, e11, e22, r;
  logic signed [NUM_W-1:0]  dw, dy, dz, sxy, sxz, syz;
  item_ctl_t                ctl_d;
  logic [2:0][NUM_W-1:0]    num_d;
  logic [VW-1:0]            rad_d;
  logic                     vld_q;
  item_ctl_t                ctl_q;
  logic [VW-1:0]            rad_q;
  logic [2:0][NUM_W-1:0]    num_q;
  logic                     rdy;

  assign a00 = $signed(mat_i[0]);
  assign a01 = $signed(mat_i[1]);
  assign a02 = $signed(mat_i[2]);
  assign a10 = $signed(mat_i[3]);
  assign a11 = $signed(mat_i[4]);
  assign a12 = $signed(mat_i[5]);
  assign a20 = $signed(mat_i[6]);
  assign a21 = $signed(mat_i[7]);
  assign a22 = $signed(mat_i[8]);

  assign tr    = 18'(a00) + 18'(a11) + 18'(a22);
  assign one_c = {{(RW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  assign e00   = RW'(a00);
  assign e11   = RW'(a11);
  assign e22   = RW'(a22);

  assign dw  = NUM_W'(a21) - NUM_W'(a12);
  assign dy  = NUM_W'(a02) - NUM_W'(a20);
  assign dz  = NUM_W'(a10) - NUM_W'(a01);
  assign sxy = NUM_W'(a01) + NUM_W'(a10);
  assign sxz = NUM_W'(a02) + NUM_W'(a20);
  assign syz = NUM_W'(a12) + NUM_W'(a21);

  // strict compares: ties fall through to the later pivot
  always_comb begin
    if (tr > 18'sd0) begin
      ctl_d.pc = PC_TRACE;
      r        = RW'(tr) + one_c;
      num_d    = {dz, dy, dw};
    end else if (a00 > a11 && a00 > a22) begin
      ctl_d.pc = PC_XX;
      r        = one_c + e00 - e11 - e22;
      num_d    = {sxz, sxy, dw};
    end else if (a11 > a22) begin
      ctl_d.pc = PC_YY;
      r        = one_c + e11 - e00 - e22;
      num_d    = {syz, sxy, dy};
    end else begin
      ctl_d.pc = PC_ZZ;
      r        = one_c + e22 - e00 - e11;
      num_d    = {syz, sxz, dz};
    end
    ctl_d.degen = (r <= RW'(0));
    rad_d       = ctl_d.degen ? '0 : {r[RU-1:0], {FRAC_BITS{1'b0}}};
  end

  assign rdy        = ~vld_q | out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      ctl_q <= ctl_d;
      rad_q <= rad_d;
      num_q <= num_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_ctl_o   = ctl_q;
  assign out_rad_o   = rad_q;
  assign out_num_o   = num_q;

endmodule
`default_nettype wire

[rtl/rmq_sqrt.sv]
`default_nettype none
module rmq_sqrt #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire rmq_pkg::item_ctl_t                in_ctl_i,
  input  wire logic [rmq_pkg::rad_ubits(FRAC_BITS)+FRAC_BITS-1:0] in_rad_i,
  input  wire logic [2:0][rmq_pkg::NUM_W-1:0]    in_num_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output rmq_pkg::item_ctl_t                     out_ctl_o,
  output logic [rmq_pkg::sqrt_bits(FRAC_BITS)-1:0] out_root_o,
  output logic [2:0][rmq_pkg::NUM_W-1:0]         out_num_o
);
  import rmq_pkg::*;

  localparam int VW = rad_ubits(FRAC_BITS) + FRAC_BITS;
  localparam int SW = sqrt_bits(FRAC_BITS);
  localparam int CS = 2 * SW + 1;

  logic [SW-1:0]         vld_q;
  logic [SW:0]           rdy;
  item_ctl_t             ctl_q  [SW];
  logic [VW-1:0]         x_q    [SW];
  logic [SW-1:0]         root_q [SW];
  logic [2:0][NUM_W-1:0] num_q  [SW];

  assign rdy[SW]     = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[SW-1];
  assign out_ctl_o   = ctl_q[SW-1];
  assign out_root_o  = root_q[SW-1];
  assign out_num_o   = num_q[SW-1];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int B = SW - 1 - k;
    logic                  v_in;
    item_ctl_t             c_in;
    logic [VW-1:0]         x_in;
    logic [SW-1:0]         r_in;
    logic [2:0][NUM_W-1:0] n_in;
    logic [CS-1:0]         xe, cand;
    logic                  take;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign c_in = in_ctl_i;
      assign x_in = in_rad_i;
      assign r_in = '0;
      assign n_in = in_num_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign c_in = ctl_q[k-1];
      assign x_in = x_q[k-1];
      assign r_in = root_q[k-1];
      assign n_in = num_q[k-1];
    end

    assign xe   = CS'(x_in);
    assign cand = (CS'(r_in) << (B + 1)) + (CS'(1) << (2 * B));
    assign take = (xe >= cand);
    assign rdy[k] = ~vld_q[k] | rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        ctl_q[k]  <= c_in;
        num_q[k]  <= n_in;
        x_q[k]    <= take ? VW'(xe - cand) : x_in;
        root_q[k] <= take ? (r_in | (SW'(1) << B)) : r_in;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rmq_div.sv]
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire rmq_pkg::item_ctl_t                in_ctl_i,
  input  wire logic [rmq_pkg::sqrt_bits(FRAC_BITS)-1:0] in_root_i,
  input  wire logic [2:0][rmq_pkg::NUM_W-1:0]    in_num_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output rmq_pkg::item_ctl_t                     out_ctl_o,
  output logic [rmq_pkg::ELEM_W-1:0]             out_piv_o,
  output logic [2:0][rmq_pkg::QUO_W-1:0]         out_quo_o,
  output logic [2:0]                             out_neg_o
);
  import rmq_pkg::*;

  localparam int SW = sqrt_bits(FRAC_BITS);
  localparam int NW = NUM_W + FRAC_BITS + 1;
  localparam int CW = (NW > SW + QUO_W) ? NW : SW + QUO_W;
  localparam int PW = (SW + 1 > ELEM_W + 1) ? SW + 1 : ELEM_W + 1;
  localparam int NS = QUO_W + 1;

  logic [NS-1:0]         vld_q;
  logic [NS:0]           rdy;
  item_ctl_t             ctl_q [NS];
  logic [ELEM_W-1:0]     piv_q [NS];
  logic [SW:0]           d_q   [NS];
  logic [2:0]            neg_q [NS];
  logic [2:0][CW-1:0]    rem_q [NS];
  logic [2:0][QUO_W-1:0] quo_q [NS];

  logic [PW-1:0]         pf;
  logic [ELEM_W-1:0]     piv_d;
  logic [2:0]            neg_d;
  logic [2:0][CW-1:0]    num_scaled;

  // pivot component: s/2 rounded half up, saturated
  always_comb begin
    pf    = (PW'(in_root_i) + PW'(1)) >> 1;
    piv_d = (pf > PW'(32767)) ? ELEM_W'(32767) : pf[ELEM_W-1:0];
  end

  // numerator (|num| << F) + s carries the round to nearest
  for (genvar l = 0; l < 3; l++) begin : g_setup
    logic [NUM_W-1:0] mag;
    assign neg_d[l]      = in_num_i[l][NUM_W-1];
    assign mag           = neg_d[l] ? NUM_W'(-in_num_i[l]) : in_num_i[l];
    assign num_scaled[l] = CW'({mag, {FRAC_BITS{1'b0}}}) + CW'(in_root_i);
  end

  assign rdy[NS]     = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_ctl_o   = ctl_q[NS-1];
  assign out_piv_o   = piv_q[NS-1];
  assign out_quo_o   = quo_q[NS-1];
  assign out_neg_o   = neg_q[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic v_in;
    assign rdy[k] = ~vld_q[k] | rdy[k+1];

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_in) begin
          ctl_q[k] <= in_ctl_i;
          piv_q[k] <= piv_d;
          d_q[k]   <= {in_root_i, 1'b0};
          neg_q[k] <= neg_d;
          rem_q[k] <= num_scaled;
          quo_q[k] <= '0;
        end
      end
    end else begin : g_bit
      // restoring step for quotient bit B; the top bit marks overflow
      localparam int B = QUO_W - k;
      logic [2:0][CW-1:0]    rem_d;
      logic [2:0][QUO_W-1:0] quo_d;
      logic [CW-1:0]         dsh;
      assign v_in = vld_q[k-1];
      assign dsh  = CW'(d_q[k-1]) << B;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        logic ge;
        assign ge       = (rem_q[k-1][l] >= dsh);
        assign rem_d[l] = ge ? (rem_q[k-1][l] - dsh) : rem_q[k-1][l];
        assign quo_d[l] = ge ? (quo_q[k-1][l] | (QUO_W'(1) << B)) : quo_q[k-1][l];
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_in) begin
          ctl_q[k] <= ctl_q[k-1];
          piv_q[k] <= piv_q[k-1];
          d_q[k]   <= d_q[k-1];
          neg_q[k] <= neg_q[k-1];
          rem_q[k] <= rem_d;
          quo_q[k] <= quo_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= v_in;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Throughput: one item per cycle while the output is not stalled, set by the bit-per-stage
// square root and divider pipelines, which sit between the prep register and the output register.
// A stalled output holds only the stages behind it; bubbles ahead of a stall still fill.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; no item is in flight after it.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic [63:0]       m_axis_tdata,
  // pivot_case [1:0], degenerate [2]
  output logic [2:0]        m_axis_tuser
);
  import rmq_pkg::*;

  localparam int VW = rad_ubits(FRAC_BITS) + FRAC_BITS;
  localparam int SW = sqrt_bits(FRAC_BITS);

  logic                  p_vld, p_rdy;
  item_ctl_t             p_ctl;
  logic [VW-1:0]         p_rad;
  logic [2:0][NUM_W-1:0] p_num;
  logic                  q_vld, q_rdy;
  item_ctl_t             q_ctl;
  logic [SW-1:0]         q_root;
  logic [2:0][NUM_W-1:0] q_num;
  logic                  d_vld, d_rdy;
  item_ctl_t             d_ctl;
  logic [ELEM_W-1:0]     d_piv;
  logic [2:0][QUO_W-1:0] d_quo;
  logic [2:0]            d_neg;

  logic [2:0][ELEM_W-1:0] comp;
  logic [63:0]            data_d;
  logic                   o_vld_q;
  logic [63:0]            o_data_q;
  logic [2:0]             o_user_q;

  rmq_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mat_i       (s_axis_tdata),
    .out_valid_o (p_vld),
    .out_ready_i (p_rdy),
    .out_ctl_o   (p_ctl),
    .out_rad_o   (p_rad),
    .out_num_o   (p_num)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_vld),
    .in_ready_o  (p_rdy),
    .in_ctl_i    (p_ctl),
    .in_rad_i    (p_rad),
    .in_num_i    (p_num),
    .out_valid_o (q_vld),
    .out_ready_i (q_rdy),
    .out_ctl_o   (q_ctl),
    .out_root_o  (q_root),
    .out_num_o   (q_num)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_vld),
    .in_ready_o  (q_rdy),
    .in_ctl_i    (q_ctl),
    .in_root_i   (q_root),
    .in_num_i    (q_num),
    .out_valid_o (d_vld),
    .out_ready_i (d_rdy),
    .out_ctl_o   (d_ctl),
    .out_piv_o   (d_piv),
    .out_quo_o   (d_quo),
    .out_neg_o   (d_neg)
  );

  // clamp quotient to 32768, apply sign, saturate to 16 bits
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [ELEM_W:0] mag;
    assign mag = (d_quo[l] >= QUO_W'(32768)) ? (ELEM_W+1)'(32768) : d_quo[l][ELEM_W:0];
    always_comb begin
      if (d_neg[l]) begin
        comp[l] = ELEM_W'(-mag);
      end else if (mag > (ELEM_W+1)'(32767)) begin
        comp[l] = ELEM_W'(32767);
      end else begin
        comp[l] = mag[ELEM_W-1:0];
      end
    end
  end

  // the branch's own slot takes the pivot, the lanes fill the rest in order; a degenerate item is all zero
  always_comb begin
    case (d_ctl.pc)
      PC_TRACE: data_d = {comp[2], comp[1], comp[0], d_piv};
      PC_XX:    data_d = {comp[2], comp[1], d_piv, comp[0]};
      PC_YY:    data_d = {comp[2], d_piv, comp[1], comp[0]};
      PC_ZZ:    data_d = {d_piv, comp[2], comp[1], comp[0]};
      default:  data_d = '0;
    endcase
    if (d_ctl.degen) begin
      data_d = '0;
    end
  end

  assign d_rdy = ~o_vld_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (d_rdy) begin
      o_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && d_vld) begin
      o_data_q <= data_d;
      o_user_q <= {d_ctl.degen, d_ctl.pc};
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

endmodule
`default_nettype wire

[rtl/rmq_checker.sv]
`default_nettype none
module rmq_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser
);
  import rmq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == 64'd0)
    else $error("degenerate item carries a nonzero quaternion");

  a_trace_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == PC_TRACE |-> !m_axis_tuser[2])
    else $error("trace branch flagged degenerate");

  a_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == PC_TRACE |-> !m_axis_tdata[15])
    else $error("trace branch scalar part negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
